@@ sv/esb_pkg.sv @@
package esb_pkg;

    localparam int SPACE_DIMS  = 3;
    localparam int NUM_ENTRIES = SPACE_DIMS * SPACE_DIMS;

    localparam int GRAD_W    = 24;
    localparam int WGT_W     = 24;
    localparam int MOD_W     = 32;
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BULK  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHEAR = 1'd1;

    localparam int PROD_W = 2 * GRAD_W;      // exact gradient product, Q.40
    localparam int P_W    = 28;              // rounded product, Q.20
    localparam int REST_W = P_W + 1;         // sum of two rounded products
    localparam int M_W    = 35;              // signed modulus, Q.8
    localparam int BR_W   = M_W + REST_W;    // bracket, Q.28
    localparam int MAG_W  = BR_W - 1;
    localparam int LO_W   = 32;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int HIW_W  = HI_W + WGT_W;
    localparam int LOW_W  = LO_W + WGT_W;
    localparam int R_W    = 60;
    localparam int OUT_W  = 48;

    localparam int N_STAGES = 8;

    // reciprocal of three, exact for any 32-bit dividend with a shift of 33
    localparam logic [MOD_W-1:0] RECIP3 = 32'hAAAA_AAAB;
    localparam int RECIP3_SHIFT = 33;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_i_x;
        logic signed [GRAD_W-1:0] grad_i_y;
        logic signed [GRAD_W-1:0] grad_i_z;
        logic signed [GRAD_W-1:0] grad_j_x;
        logic signed [GRAD_W-1:0] grad_j_y;
        logic signed [GRAD_W-1:0] grad_j_z;
        logic        [WGT_W-1:0]  jacobian_weight;
    } esb_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] k_xx;
        logic signed [OUT_W-1:0] k_xy;
        logic signed [OUT_W-1:0] k_xz;
        logic signed [OUT_W-1:0] k_yx;
        logic signed [OUT_W-1:0] k_yy;
        logic signed [OUT_W-1:0] k_yz;
        logic signed [OUT_W-1:0] k_zx;
        logic signed [OUT_W-1:0] k_zy;
        logic signed [OUT_W-1:0] k_zz;
    } esb_out_t;

    typedef struct packed {
        logic signed [M_W-1:0] m_diag;
        logic signed [M_W-1:0] m_off;
        logic signed [M_W-1:0] shear;
    } esb_mod_t;

    typedef struct packed {
        logic mag_ld;
        logic mul_ld;
        logic out_ld;
    } esb_scale_ctl_t;

endpackage

@@ sv/esb_moduli.sv @@
// Material registers and derived moduli K+4G/3, K-2G/3.
// Derived values are registered after a write, through q_reg and then moduli_reg.
module esb_moduli
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [esb_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [esb_pkg::MOD_W-1:0]        cfg_data,
    output esb_pkg::esb_mod_t                moduli
);

    localparam int Q_W = esb_pkg::MOD_W - 1;
    localparam int PRD_W = 2 * esb_pkg::MOD_W;

    logic [esb_pkg::MOD_W-1:0] bulk_reg;
    logic [esb_pkg::MOD_W-1:0] shear_reg;
    logic [Q_W-1:0]            q_reg;
    logic [PRD_W-1:0]          q_prod;
    logic [1:0]                rem;
    logic [1:0]                c4_adj;
    logic                      c2_adj;
    logic [esb_pkg::MOD_W:0]   c4;
    logic [esb_pkg::MOD_W-1:0] c2;
    esb_pkg::esb_mod_t         moduli_reg;
    esb_pkg::esb_mod_t         moduli_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bulk_reg  <= '0;
            shear_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                esb_pkg::REG_BULK:  bulk_reg  <= cfg_data;
                esb_pkg::REG_SHEAR: shear_reg <= cfg_data;
            endcase
        end
    end

    // G = 3q + r
    assign q_prod = PRD_W'(shear_reg) * PRD_W'(esb_pkg::RECIP3);

    // r only needs two bits: G - 3q mod 4
    assign rem = shear_reg[1:0] - 2'(q_reg[1:0] * 2'd3);

    always_comb
    begin
        // floor((4r+1)/3) and floor((2r+1)/3)
        case (rem)
            2'd0:    begin c4_adj = 2'd0; c2_adj = 1'b0; end
            2'd1:    begin c4_adj = 2'd1; c2_adj = 1'b1; end
            2'd2:    begin c4_adj = 2'd3; c2_adj = 1'b1; end
            default: begin c4_adj = 2'd0; c2_adj = 1'b0; end
        endcase
        c4 = {q_reg, 2'b00} + (esb_pkg::MOD_W + 1)'(c4_adj);
        c2 = {q_reg, 1'b0} + esb_pkg::MOD_W'(c2_adj);
        moduli_next.m_diag = esb_pkg::M_W'(bulk_reg) + esb_pkg::M_W'(c4);
        moduli_next.m_off  = esb_pkg::M_W'(bulk_reg) - esb_pkg::M_W'(c2);
        moduli_next.shear  = esb_pkg::M_W'(shear_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg      <= '0;
            moduli_reg <= '0;
        end
        else
        begin
            q_reg      <= q_prod[esb_pkg::RECIP3_SHIFT +: Q_W];
            moduli_reg <= moduli_next;
        end
    end

    assign moduli = moduli_reg;

endmodule

@@ sv/esb_scale.sv @@
// Bracket times weight, rounded to Q.16 half away from zero, saturated.
// Three register stages: magnitude, partial products, sum and clamp.
module esb_scale
(
    input  logic                                clk,
    input  esb_pkg::esb_scale_ctl_t             ctl,
    input  logic signed [esb_pkg::BR_W-1:0]     bracket,
    input  logic        [esb_pkg::WGT_W-1:0]    weight,
    output logic signed [esb_pkg::OUT_W-1:0]    k
);

    localparam int SUM_W = esb_pkg::LOW_W + 1;
    localparam int FRAC_W = SUM_W - 28;
    localparam logic [esb_pkg::R_W-1:0] POS_MAX = esb_pkg::R_W'({1'b0, {(esb_pkg::OUT_W-1){1'b1}}});
    localparam logic [esb_pkg::R_W-1:0] NEG_MAX = esb_pkg::R_W'({1'b1, {(esb_pkg::OUT_W-1){1'b0}}});

    logic                          neg_reg;
    logic [esb_pkg::MAG_W-1:0]     mag_reg;
    logic                          neg2_reg;
    logic [esb_pkg::HIW_W-1:0]     hiw_reg;
    logic [esb_pkg::LOW_W-1:0]     low_reg;
    logic signed [esb_pkg::OUT_W-1:0] k_reg;

    logic [esb_pkg::BR_W-1:0]      mag_full;
    logic [SUM_W-1:0]              lo_sum;
    logic [esb_pkg::R_W-1:0]       r;
    logic [esb_pkg::R_W-1:0]       r_sat;
    logic signed [esb_pkg::OUT_W-1:0] k_next;

    assign mag_full = bracket[esb_pkg::BR_W-1] ? -bracket : bracket;

    always_comb
    begin
        lo_sum = {1'b0, low_reg} + SUM_W'(1 << 27);
        r = esb_pkg::R_W'({hiw_reg, 4'b0000}) + esb_pkg::R_W'(lo_sum[SUM_W-1 -: FRAC_W]);
        if (neg2_reg)
        begin
            r_sat  = (r > NEG_MAX) ? NEG_MAX : r;
            k_next = -(esb_pkg::OUT_W'(r_sat));
        end
        else
        begin
            r_sat  = (r > POS_MAX) ? POS_MAX : r;
            k_next = esb_pkg::OUT_W'(r_sat);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mag_ld)
        begin
            neg_reg <= bracket[esb_pkg::BR_W-1];
            mag_reg <= mag_full[esb_pkg::MAG_W-1:0];
        end
        if (ctl.mul_ld)
        begin
            neg2_reg <= neg_reg;
            hiw_reg  <= mag_reg[esb_pkg::MAG_W-1 -: esb_pkg::HI_W] * esb_pkg::HIW_W'(weight);
            low_reg  <= mag_reg[esb_pkg::LO_W-1:0] * esb_pkg::LOW_W'(weight);
        end
        if (ctl.out_ld)
            k_reg <= k_next;
    end

    assign k = k_reg;

endmodule

@@ sv/elastic_stiffness_block.sv @@
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   esb_in_t: gradients i, j and weight
// rsp       out        rsp_valid/rsp_ready   esb_out_t: 3x3 stiffness, row-major
// cfg       in         cfg_we                cfg_idx selects bulk or shear modulus
//
// One transaction per cycle sustained while rsp_ready stays high; eight register
// stages, and rsp_valid is the valid bit of the last of them.
// Each stage has its own valid bit and loads whenever it is empty or the stage
// after it is empty or moving, so bubbles close up under a stall and nothing is dropped.
// Reset clears the valid bits and both modulus registers to zero.
// A modulus write reaches the datapath through the registers of esb_moduli.
module elastic_stiffness_block
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  esb_pkg::esb_in_t               req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output esb_pkg::esb_out_t              rsp,
    input  logic                           cfg_we,
    input  logic [esb_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [esb_pkg::MOD_W-1:0]      cfg_data
);

    localparam int NS = esb_pkg::N_STAGES;
    localparam int D  = esb_pkg::SPACE_DIMS;
    localparam int NE = esb_pkg::NUM_ENTRIES;

    // ------------------------------------------------------------------
    // Stage control
    // Stages: 0 input, 1 gradient products, 2 rounding, 3 modulus
    // products, 4 bracket sum, 5-7 weight scaling (inside esb_scale).
    // ------------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] rdy;
    logic [NS-1:0] up_valid;
    logic [NS-1:0] ld;

    assign up_valid = {valid_reg[NS-2:0], req_valid};
    assign ld       = up_valid & rdy;

    always_comb
    begin
        rdy[NS-1] = !valid_reg[NS-1] || rsp_ready;
        for (int s = NS - 2; s >= 0; s--)
            rdy[s] = !valid_reg[s] || rdy[s+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int s = 0; s < NS; s++)
                if (rdy[s])
                    valid_reg[s] <= up_valid[s];
        end
    end

    assign req_ready = rdy[0];
    assign rsp_valid = valid_reg[NS-1];

    // ------------------------------------------------------------------
    // Moduli
    // ------------------------------------------------------------------
    esb_pkg::esb_mod_t moduli;

    esb_moduli u_moduli
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .moduli   (moduli)
    );

    // ------------------------------------------------------------------
    // Stage 0: capture the transaction
    // ------------------------------------------------------------------
    logic signed [esb_pkg::GRAD_W-1:0] gi_reg [D];
    logic signed [esb_pkg::GRAD_W-1:0] gj_reg [D];
    logic        [esb_pkg::WGT_W-1:0]  w_pipe_reg [6];

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            gi_reg[0]     <= req.grad_i_x;
            gi_reg[1]     <= req.grad_i_y;
            gi_reg[2]     <= req.grad_i_z;
            gj_reg[0]     <= req.grad_j_x;
            gj_reg[1]     <= req.grad_j_y;
            gj_reg[2]     <= req.grad_j_z;
            w_pipe_reg[0] <= req.jacobian_weight;
        end
        // weight rides alongside up to the scaling multiply
        for (int s = 1; s < 6; s++)
            if (ld[s])
                w_pipe_reg[s] <= w_pipe_reg[s-1];
    end

    // ------------------------------------------------------------------
    // Stages 1-4, one lane per entry (a,b), index a*D+b
    // ------------------------------------------------------------------
    logic signed [esb_pkg::PROD_W-1:0] prod_reg [NE];
    logic signed [esb_pkg::P_W-1:0]    p_reg    [NE];
    logic signed [esb_pkg::BR_W-1:0]   t1_reg   [NE];
    logic signed [esb_pkg::BR_W-1:0]   t2_reg   [NE];
    logic signed [esb_pkg::BR_W-1:0]   br_reg   [NE];
    logic signed [esb_pkg::OUT_W-1:0]  k_res    [NE];

    esb_pkg::esb_scale_ctl_t scale_ctl;

    assign scale_ctl.mag_ld = ld[5];
    assign scale_ctl.mul_ld = ld[6];
    assign scale_ctl.out_ld = ld[7];

    for (genvar a = 0; a < D; a++)
    begin : g_row
        for (genvar b = 0; b < D; b++)
        begin : g_col
            localparam int IDX = a * D + b;
            logic signed [esb_pkg::PROD_W-1:0] rnd_sum;
            logic signed [esb_pkg::REST_W-1:0] rest;
            logic signed [esb_pkg::BR_W-1:0]   t1_next;
            logic signed [esb_pkg::BR_W-1:0]   t2_next;

            // half away from zero: add 2^19, less one when negative, then floor
            assign rnd_sum = prod_reg[IDX] + esb_pkg::PROD_W'(1 << 19)
                             - esb_pkg::PROD_W'(prod_reg[IDX][esb_pkg::PROD_W-1]);

            if (a == b)
            begin : g_diag
                // shear carries the other two axes of the divergence term
                assign rest = esb_pkg::REST_W'(p_reg[((a + 1) % D) * (D + 1)])
                            + esb_pkg::REST_W'(p_reg[((a + 2) % D) * (D + 1)]);
                assign t1_next = moduli.m_diag * esb_pkg::REST_W'(p_reg[IDX]);
                assign t2_next = moduli.shear * rest;
            end
            else
            begin : g_off
                assign rest    = esb_pkg::REST_W'(p_reg[b * D + a]);
                assign t1_next = moduli.m_off * esb_pkg::REST_W'(p_reg[IDX]);
                assign t2_next = moduli.shear * rest;
            end

            always_ff @(posedge clk)
            begin
                if (ld[1])
                    prod_reg[IDX] <= gi_reg[a] * gj_reg[b];
                if (ld[2])
                    p_reg[IDX] <= rnd_sum[esb_pkg::PROD_W-1 -: esb_pkg::P_W];
                if (ld[3])
                begin
                    t1_reg[IDX] <= t1_next;
                    t2_reg[IDX] <= t2_next;
                end
                if (ld[4])
                    br_reg[IDX] <= t1_reg[IDX] + t2_reg[IDX];
            end

            esb_scale u_scale
            (
                .clk     (clk),
                .ctl     (scale_ctl),
                .bracket (br_reg[IDX]),
                .weight  (w_pipe_reg[5]),
                .k       (k_res[IDX])
            );
        end
    end

    always_comb
    begin
        rsp.k_xx = k_res[0];
        rsp.k_xy = k_res[1];
        rsp.k_xz = k_res[2];
        rsp.k_yx = k_res[3];
        rsp.k_yy = k_res[4];
        rsp.k_yz = k_res[5];
        rsp.k_zx = k_res[6];
        rsp.k_zy = k_res[7];
        rsp.k_zz = k_res[8];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a full pipe only takes a transaction when the result is leaving
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> (!(&valid_reg) || rsp_ready))
        else $error("input taken while pipeline full and output stalled");

    // an accepted transaction lands in the input stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> valid_reg[0])
        else $error("accepted transaction lost at input stage");

    // a stalled mid-pipe stage keeps its transaction
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[3] && !rdy[3]) |=> valid_reg[3])
        else $error("stalled stage dropped its transaction");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int HALF_PERIOD     = 5;
    localparam int IDLE_PCT        = 19;        // idle cycles per hundred, each side
    localparam int HOLD_CYCLES     = 80;        // long receiver hold-off, fills the pipe
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 192;       // 6 x 192 random transactions
    localparam int LIMIT_TIME      = 5_000_000; // far above the slowest run

    // Fixed-point corners
    localparam logic [esb_pkg::MOD_W-1:0]         MOD_MAX   = '1;
    localparam logic signed [esb_pkg::GRAD_W-1:0] G_MAX     = 24'sh7FFFFF;
    localparam logic signed [esb_pkg::GRAD_W-1:0] G_MIN     = 24'sh800000;
    localparam logic signed [esb_pkg::GRAD_W-1:0] G_ONE     = 24'sh100000;   // 1.0 in Q4.20
    localparam logic signed [esb_pkg::GRAD_W-1:0] G_NONE    = 24'shF00000;   // -1.0
    localparam logic signed [esb_pkg::GRAD_W-1:0] G_HALFONE = 24'sh080000;   // 0.5, also 2^19
    localparam logic signed [esb_pkg::GRAD_W-1:0] G_BELOW   = 24'sh07FFFF;   // just under 2^19
    localparam logic signed [esb_pkg::GRAD_W-1:0] G_LSB     = 24'sh000001;
    localparam logic signed [esb_pkg::GRAD_W-1:0] G_NLSB    = 24'shFFFFFF;
    localparam logic signed [esb_pkg::GRAD_W-1:0] G_ZERO    = '0;
    localparam logic [esb_pkg::GRAD_W-1:0]        G_SPAN    = 24'h200000;    // +-2.0
    localparam logic [esb_pkg::WGT_W-1:0]         W_MAX     = '1;
    localparam logic [esb_pkg::WGT_W-1:0]         W_ONE     = 24'h010000;    // 1.0 in Q8.16
    localparam logic [esb_pkg::WGT_W-1:0]         W_ZERO    = '0;
    localparam logic [esb_pkg::OUT_W-1:0]         OUT_MAX   =
        {1'b0, {(esb_pkg::OUT_W-1){1'b1}}};
    localparam logic [esb_pkg::OUT_W-1:0]         OUT_MIN   =
        {1'b1, {(esb_pkg::OUT_W-1){1'b0}}};
    localparam logic [esb_pkg::OUT_W-1:0]         OUT_ZERO  = '0;

    localparam logic signed [esb_pkg::GRAD_W-1:0] G_CORNERS [5] =
        '{G_MAX, G_MIN, G_ZERO, G_LSB, G_NLSB};
    localparam logic [esb_pkg::WGT_W-1:0]         W_CORNERS [3] = '{W_ZERO, W_MAX, W_ONE};

    // nine entries, k_xx in the top slot, matching the packed result struct
    typedef logic [esb_pkg::NUM_ENTRIES-1:0][esb_pkg::OUT_W-1:0] entries_t;

    localparam string ENTRY_NAME [esb_pkg::NUM_ENTRIES] =
        '{"k_xx", "k_xy", "k_xz", "k_yx", "k_yy", "k_yz", "k_zx", "k_zy", "k_zz"};

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_ready;
    esb_pkg::esb_in_t              req;
    logic                          rsp_valid;
    logic                          rsp_ready;
    esb_pkg::esb_out_t             rsp;
    logic                          cfg_we;
    logic [esb_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [esb_pkg::MOD_W-1:0]     cfg_data;

    elastic_stiffness_block uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------
    // moduli as the block should hold them; reset clears both
    logic [esb_pkg::MOD_W-1:0] bulk_now  = '0;
    logic [esb_pkg::MOD_W-1:0] shear_now = '0;

    esb_pkg::esb_out_t stiffness_due [$];   // predicted results, oldest first

    int n_errors   = 0;
    int n_checked  = 0;
    int n_sent     = 0;
    int n_settings = 1;            // the reset setting counts as one
    bit steady       = 1'b0;       // both sides stop idling while set
    bit hold_request = 1'b0;       // asks the receiver for one long hold-off

    // ------------------------------------------------------------------
    // Directed table. Rows with typed set carry a value that every entry
    // must take (zero moduli, zero weight, zero gradients, saturation); the rest go
    // through the predictor. A change of moduli between rows drains the
    // pipe and rewrites both registers.
    // ------------------------------------------------------------------
    typedef struct {
        logic [esb_pkg::MOD_W-1:0] bulk;
        logic [esb_pkg::MOD_W-1:0] shear;
        esb_pkg::esb_in_t          item;
        bit                        typed;
        logic [esb_pkg::OUT_W-1:0] known;
    } dir_row_t;

    localparam int N_DIR = 17;

    dir_row_t dir_table [N_DIR] = '{
        // reset moduli: every entry zero whatever the gradients
        '{'0, '0, '{G_MAX, G_MAX, G_MAX, G_MAX, G_MAX, G_MAX, W_MAX}, 1'b1, OUT_ZERO},
        '{'0, '0, '{G_MIN, G_MAX, G_MIN, G_MAX, G_MIN, G_MAX, W_MAX}, 1'b1, OUT_ZERO},
        // largest moduli: saturation both ways
        '{MOD_MAX, MOD_MAX, '{G_MIN, G_MIN, G_MIN, G_MIN, G_MIN, G_MIN, W_MAX}, 1'b1, OUT_MAX},
        '{MOD_MAX, MOD_MAX, '{G_MIN, G_MIN, G_MIN, G_MAX, G_MAX, G_MAX, W_MAX}, 1'b1, OUT_MIN},
        '{MOD_MAX, MOD_MAX, '{G_MAX, G_MAX, G_MAX, G_MAX, G_MAX, G_MAX, W_MAX}, 1'b1, OUT_MAX},
        // zero weight, zero gradients
        '{MOD_MAX, MOD_MAX, '{G_MAX, G_MIN, G_ONE, G_MIN, G_MAX, G_ONE, W_ZERO}, 1'b1, OUT_ZERO},
        '{MOD_MAX, MOD_MAX, '{G_ZERO, G_ZERO, G_ZERO, G_ZERO, G_ZERO, G_ZERO, W_MAX}, 1'b1,
          OUT_ZERO},
        '{MOD_MAX, MOD_MAX, '{G_ONE, G_ZERO, G_ZERO, G_ONE, G_ZERO, G_ZERO, W_ONE}, 1'b0,
          OUT_ZERO},
        // product rounding: tie goes away from zero, just under the tie goes to zero
        '{MOD_MAX, MOD_MAX, '{G_LSB, G_ZERO, G_ZERO, G_HALFONE, G_ZERO, G_ZERO, W_ONE}, 1'b0,
          OUT_ZERO},
        '{MOD_MAX, MOD_MAX, '{G_NLSB, G_ZERO, G_ZERO, G_HALFONE, G_ZERO, G_ZERO, W_ONE}, 1'b0,
          OUT_ZERO},
        '{MOD_MAX, MOD_MAX, '{G_LSB, G_ZERO, G_ZERO, G_BELOW, G_ZERO, G_ZERO, W_ONE}, 1'b0,
          OUT_ZERO},
        // no bulk stiffness: off-diagonal modulus goes negative
        '{'0, MOD_MAX, '{G_ONE, G_NONE, G_HALFONE, G_HALFONE, G_ONE, G_NONE, W_ONE}, 1'b0,
          OUT_ZERO},
        '{'0, MOD_MAX, '{G_ONE, G_ONE, G_ONE, G_ONE, G_ONE, G_ONE, W_MAX}, 1'b0, OUT_ZERO},
        // no shear stiffness
        '{MOD_MAX, '0, '{G_ONE, G_ONE, G_ONE, G_ONE, G_NONE, G_HALFONE, W_ONE}, 1'b0,
          OUT_ZERO},
        // small moduli, rounding of the shear thirds
        '{32'h0000_0300, 32'h0000_0100, '{G_ONE, G_ZERO, G_ZERO, G_ZERO, G_ONE, G_ZERO, W_ONE},
          1'b0, OUT_ZERO},
        '{32'd5, 32'd1, '{G_ONE, G_ONE, G_ONE, G_ONE, G_ONE, G_ONE, W_ONE}, 1'b0, OUT_ZERO},
        '{32'd1, 32'd2, '{G_ONE, G_NONE, G_ONE, G_NONE, G_ONE, G_NONE, W_ONE}, 1'b0, OUT_ZERO}
    };

    // ------------------------------------------------------------------
    // Stiffness predictor
    // ------------------------------------------------------------------
    // Q.40 product down to Q.20, ties away from zero
    function automatic longint round_q20(input longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< 19)) >>> 20;
        return (v < 0) ? -mag : mag;
    endfunction

    // Q.28 bracket times Q.16 weight, rounded to Q.16 (ties away), saturated to 48 bits
    function automatic logic [esb_pkg::OUT_W-1:0] scaled_entry(input longint br,
                                                               input logic [esb_pkg::WGT_W-1:0] w);
        logic [127:0] mag;
        logic [127:0] r;
        logic         neg;
        neg = (br < 0);
        mag = neg ? 128'(-br) : 128'(br);
        r   = (mag * w + (128'd1 << 27)) >> 28;
        if (neg)
        begin
            if (r > 128'(OUT_MIN))
                r = 128'(OUT_MIN);
            return esb_pkg::OUT_W'(-r);
        end
        if (r > 128'(OUT_MAX))
            r = 128'(OUT_MAX);
        return esb_pkg::OUT_W'(r);
    endfunction

    function automatic esb_pkg::esb_out_t predict_stiffness(input esb_pkg::esb_in_t item);
        longint   gi [esb_pkg::SPACE_DIMS];
        longint   gj [esb_pkg::SPACE_DIMS];
        longint   pr [esb_pkg::SPACE_DIMS][esb_pkg::SPACE_DIMS];
        longint   kb, gs, m_diag, m_off, br, rest;
        entries_t v;
        int       a, b, c;
        kb     = longint'(bulk_now);
        gs     = longint'(shear_now);
        m_diag = kb + (4 * gs + 1) / 3;        // K + round(4G/3)
        m_off  = kb - (2 * gs + 1) / 3;        // K - round(2G/3), may go negative
        gi[0]  = item.grad_i_x;
        gi[1]  = item.grad_i_y;
        gi[2]  = item.grad_i_z;
        gj[0]  = item.grad_j_x;
        gj[1]  = item.grad_j_y;
        gj[2]  = item.grad_j_z;
        for (a = 0; a < esb_pkg::SPACE_DIMS; a++)
            for (b = 0; b < esb_pkg::SPACE_DIMS; b++)
                pr[a][b] = round_q20(gi[a] * gj[b]);
        for (a = 0; a < esb_pkg::SPACE_DIMS; a++)
        begin
            for (b = 0; b < esb_pkg::SPACE_DIMS; b++)
            begin
                if (a == b)
                begin
                    rest = 0;
                    for (c = 0; c < esb_pkg::SPACE_DIMS; c++)
                        if (c != a)
                            rest += pr[c][c];
                    br = m_diag * pr[a][a] + gs * rest;
                end
                else
                begin
                    br = m_off * pr[a][b] + gs * pr[b][a];
                end
                v[esb_pkg::NUM_ENTRIES - 1 - (a * esb_pkg::SPACE_DIMS + b)] =
                    scaled_entry(br, item.jacobian_weight);
            end
        end
        return esb_pkg::esb_out_t'(v);
    endfunction

    // ------------------------------------------------------------------
    // Random transaction content: full-range draws hit every bit and the
    // saturation rails, small draws keep results inside the range.
    // ------------------------------------------------------------------
    function automatic logic signed [esb_pkg::GRAD_W-1:0] rand_grad();
        case ($urandom_range(4))
            0, 1:    return esb_pkg::GRAD_W'($urandom);
            2, 3:    return esb_pkg::GRAD_W'($urandom_range(2 * G_SPAN) - G_SPAN);
            default: return G_CORNERS[$urandom_range(4)];
        endcase
    endfunction

    function automatic logic [esb_pkg::WGT_W-1:0] rand_weight();
        case ($urandom_range(2))
            0:       return esb_pkg::WGT_W'($urandom);
            1:       return esb_pkg::WGT_W'($urandom_range(4 * W_ONE));
            default: return W_CORNERS[$urandom_range(2)];
        endcase
    endfunction

    function automatic esb_pkg::esb_in_t rand_item();
        esb_pkg::esb_in_t it;
        it.grad_i_x        = rand_grad();
        it.grad_i_y        = rand_grad();
        it.grad_i_z        = rand_grad();
        it.grad_j_x        = rand_grad();
        it.grad_j_y        = rand_grad();
        it.grad_j_z        = rand_grad();
        it.jacobian_weight = rand_weight();
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offers one transaction and returns in the time step of the edge that
    // accepts it; valid stays up into the next offer unless an idle gap is drawn.
    task automatic send_item(input esb_pkg::esb_in_t item, input bit typed,
                             input logic [esb_pkg::OUT_W-1:0] known);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        n_sent++;
        if (typed)
            stiffness_due.insert(stiffness_due.size(),
                                 esb_pkg::esb_out_t'({esb_pkg::NUM_ENTRIES{known}}));
        else
            stiffness_due.insert(stiffness_due.size(), predict_stiffness(item));
    endtask

    task automatic wait_drained();
        while (stiffness_due.size() != 0)
            @(posedge clk);
    endtask

    // Moduli change only with the pipe empty. The write passes through the moduli
    // registers before it reaches the datapath, so the request side stays quiet
    // for a while after the write before it sends again.
    task automatic write_moduli(input logic [esb_pkg::MOD_W-1:0] bulk,
                                input logic [esb_pkg::MOD_W-1:0] shear);
        req_valid <= 1'b0;
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= esb_pkg::REG_BULK;
        cfg_data <= bulk;
        @(posedge clk);
        cfg_idx  <= esb_pkg::REG_SHEAR;
        cfg_data <= shear;
        @(posedge clk);
        cfg_we    <= 1'b0;
        bulk_now  = bulk;
        shear_now = shear;
        n_settings++;
        repeat (esb_pkg::N_STAGES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stalls, plus one long hold-off on request,
    // counted here so the request side keeps pushing into a full pipe.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int held;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rsp_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        esb_pkg::esb_out_t want;
        entries_t          got_e;
        entries_t          want_e;
        int                n;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (stiffness_due.size() == 0)
            begin
                n_errors++;
                $display("%0t: stiffness result with none outstanding, expected none got %h",
                         $time, rsp);
            end
            else
            begin
                want   = stiffness_due.pop_front();
                got_e  = entries_t'(rsp);
                want_e = entries_t'(want);
                n_checked++;
                for (n = 0; n < esb_pkg::NUM_ENTRIES; n++)
                begin
                    if (got_e[esb_pkg::NUM_ENTRIES - 1 - n] !==
                        want_e[esb_pkg::NUM_ENTRIES - 1 - n])
                    begin
                        n_errors++;
                        $display("%0t: %s mismatch, expected %h got %h", $time,
                                 ENTRY_NAME[n], want_e[esb_pkg::NUM_ENTRIES - 1 - n],
                                 got_e[esb_pkg::NUM_ENTRIES - 1 - n]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int r;
        int phase;
        int k;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_we    <= 1'b0;
        cfg_idx   <= esb_pkg::REG_BULK;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners; the first rows run on the reset moduli
        for (r = 0; r < N_DIR; r++)
        begin
            if (dir_table[r].bulk != bulk_now || dir_table[r].shear != shear_now)
                write_moduli(dir_table[r].bulk, dir_table[r].shear);
            send_item(dir_table[r].item, dir_table[r].typed, dir_table[r].known);
        end

        // random phases, each on its own moduli
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0, 4:    write_moduli($urandom, $urandom);
                1:       write_moduli($urandom_range(32'h00FF_FFFF), $urandom_range(32'h00FF_FFFF));
                2:       write_moduli(MOD_MAX, '0);
                3:       write_moduli('0, MOD_MAX);
                default: write_moduli($urandom_range(1000), $urandom_range(1000));
            endcase
            steady = (phase == 2);     // one whole phase back to back, no gaps
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (phase == 1 && k == 60)
                    hold_request = 1'b1;   // receiver stops; pipe fills, req_ready drops
                if (phase == 4 && k == ITEMS_PER_PHASE / 2)
                begin
                    req_valid <= 1'b0;     // sender waits for every result
                    wait_drained();
                end
                send_item(rand_item(), 1'b0, OUT_ZERO);
            end
            steady = 1'b0;
        end

        req_valid <= 1'b0;
        wait_drained();
        repeat (2 * esb_pkg::N_STAGES) @(posedge clk);

        $display("Checked %0d stiffness results from %0d transactions over %0d moduli settings.",
                 n_checked, n_sent, n_settings);
        $display("Covered field extremes, product and output rounding, saturation, negative");
        $display("off-diagonal modulus, a long response hold-off and a full drain.");
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #(LIMIT_TIME);
        $display("%0t: timed out, %0d stiffness results outstanding", $time,
                 stiffness_due.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
